// ===== hw/rtl/cpt_pkg.sv =====
`default_nettype none
package cpt_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COUNT,
		ST_PRIME_INIT,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_PRIME_DONE,
		ST_ROTATE,
		ST_ROT_WAIT,
		ST_REPORT
	} cpt_state_t;

	// which remainder is being checked
	typedef enum logic [1:0] {
		DIV_TWO,
		DIV_THREE,
		DIV_LOW,
		DIV_HIGH
	} div_sel_t;

	typedef struct packed {
		logic     load;        // take a new input word
		logic     count_step;  // one digit-count step
		logic     prime_init;  // select value under test
		logic     div_start;   // launch one remainder
		div_sel_t div_sel;
		logic     next_pair;   // divisor += 6
		logic     rot_start;   // launch rotation divide by ten
		logic     rot_load;    // take rotated value
		logic     prime_of_input; // the test is on the input itself
		logic     record_prime;
		logic     verdict;     // outcome of the last prime test
		logic     fail_circ;
		logic     out_valid;
	} cpt_cmd_t;

	typedef struct packed {
		logic count_done;
		logic too_long;
		logic small_decided;  // n <= 3
		logic small_prime;
		logic div_done;
		logic rem_zero;
		logic sq_over;        // d*d > n
		logic last_rotation;
	} cpt_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cpt_divider.sv =====
`default_nettype none
// restoring divider, one quotient bit per cycle
module cpt_divider
	import cpt_pkg::*;
#(
	parameter int W = 30
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic [W-1:0]      quotient,
	output logic [W-1:0]      remainder
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  quo_q;
	logic [W:0]    rem_q;
	logic [W-1:0]  dsr_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic [W:0]    shifted;
	logic [W:0]    diff;

	assign shifted = {rem_q[W-1:0], quo_q[W-1]};
	assign diff    = shifted - {1'b0, dsr_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (run_q) begin
			if (!diff[W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q[W-1:0];

endmodule
`default_nettype wire

// ===== hw/rtl/cpt_datapath.sv =====
`default_nettype none
module cpt_datapath
	import cpt_pkg::*;
#(
	parameter int MAX_DIGITS = 9
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [29:0] value,
	input  wire cpt_cmd_t    cmd,
	output cpt_status_t      status,
	output logic             is_circular,
	output logic             is_prime
);
	localparam int W = 30;

	logic [W-1:0] value_q;
	logic [W-1:0] pow_q;
	logic [3:0]   len_q;
	logic         long_q;
	logic [W-1:0] n_q;        // value under test
	logic [W-1:0] work_q;     // current rotation
	logic [15:0]  d_q;
	logic [3:0]   rot_q;
	logic         circ_q;
	logic         prime_q;
	logic [W-1:0] lead_q;     // (n % 10) * pow
	logic [W-1:0] quo10_q;    // n / 10
	logic         quick_q;    // remainder by two or three ready
	logic         quick_zero_q;

	logic         div_start;
	logic [W-1:0] div_dsr;
	logic         div_done;
	logic [W-1:0] div_quo;
	logic [W-1:0] div_rem;
	logic [33:0]  dsq;
	logic [33:0]  next_pow;
	logic [59:0]  recip_prod;
	logic [3:0]   rem10;

	// n mod 3 is zero, summing base-4 digits
	function automatic logic mod3_zero(input logic [W-1:0] n);
		logic [5:0] s;
		logic [3:0] t;
		logic [2:0] u;
		s = '0;
		for (int i = 0; i < 15; i++) s = s + 6'(n[2*i +: 2]);
		t = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
		u = 3'(t[1:0]) + 3'(t[3:2]);
		return u inside {3'd0, 3'd3};
	endfunction

	// divisor per request, only 6k-1 and 6k+1 go to the divider
	always_comb begin
		case (cmd.div_sel)
			DIV_HIGH: div_dsr = W'(d_q) + W'(2);
			default:  div_dsr = W'(d_q);
		endcase
	end
	assign div_start = cmd.div_start && (cmd.div_sel inside {DIV_LOW, DIV_HIGH});

	cpt_divider #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(n_q), .divisor(div_dsr),
		.done(div_done), .quotient(div_quo), .remainder(div_rem)
	);

	// digit counting by comparing against the growing power of ten
	assign next_pow = 34'(pow_q) * 34'd10;

	// divide by ten through a reciprocal, remainder from the low bits
	assign recip_prod = 60'(work_q) * 60'(30'h33333334);
	assign rem10      = work_q[3:0] - 4'(quo10_q[3:0] * 4'd10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			circ_q      <= 1'b0;
			prime_q     <= 1'b0;
			quick_q     <= 1'b0;
			is_circular <= 1'b0;
			is_prime    <= 1'b0;
		end else begin
			quick_q <= cmd.div_start && (cmd.div_sel inside {DIV_TWO, DIV_THREE});
			if (cmd.load) circ_q <= 1'b1;
			if (cmd.fail_circ) circ_q <= 1'b0;
			if (cmd.record_prime) prime_q <= cmd.verdict;
			if (cmd.out_valid) begin
				is_circular <= circ_q;
				is_prime    <= prime_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		lead_q       <= W'(rem10 * pow_q);
		quick_zero_q <= (cmd.div_sel == DIV_TWO) ? !n_q[0] : mod3_zero(n_q);
		if (cmd.load) begin
			value_q <= value;
			pow_q   <= W'(1);
			len_q   <= 4'd1;
			long_q  <= 1'b0;
			work_q  <= value;
			rot_q   <= '0;
		end
		if (cmd.count_step) begin
			if (len_q >= 4'(MAX_DIGITS)) long_q <= 1'b1;
			else begin
				len_q <= len_q + 1'b1;
				pow_q <= next_pow[W-1:0];
			end
		end
		if (cmd.prime_init) begin
			n_q <= cmd.prime_of_input ? value_q : work_q;
			d_q <= 16'd5;
		end
		if (cmd.next_pair) d_q <= d_q + 16'd6;
		if (cmd.rot_start) quo10_q <= W'(recip_prod[59:33]);
		if (cmd.rot_load) begin
			work_q <= lead_q + quo10_q;
			rot_q  <= rot_q + 1'b1;
		end
	end

	assign dsq = 34'(d_q) * 34'(d_q);

	always_comb begin
		status.count_done    = 34'(value_q) < next_pow;
		status.too_long      = long_q;
		status.small_decided = n_q <= W'(3);
		status.small_prime   = n_q >= W'(2);
		status.div_done      = div_done | quick_q;
		status.rem_zero      = quick_q ? quick_zero_q : (div_rem == '0);
		status.sq_over       = dsq > 34'(n_q);
		status.last_rotation = (rot_q + 1'b1) == len_q;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/cpt_ctrl.sv =====
`default_nettype none
module cpt_ctrl
	import cpt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire cpt_status_t status,
	output cpt_cmd_t         cmd
);
	cpt_state_t state_q, state_d;
	div_sel_t   sel_q, sel_d;
	logic       on_input_q, on_input_d;
	logic       verdict_q, verdict_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sel_q      <= DIV_TWO;
			on_input_q <= 1'b1;
			verdict_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			sel_q      <= sel_d;
			on_input_q <= on_input_d;
			verdict_q  <= verdict_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		sel_d      = sel_q;
		on_input_d = on_input_q;
		verdict_d  = verdict_q;
		cmd        = '0;
		cmd.div_sel = sel_q;
		cmd.prime_of_input = on_input_q;
		cmd.verdict = verdict_q;
		busy = state_q != ST_IDLE;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load   = 1'b1;
					on_input_d = 1'b1;
					state_d    = ST_COUNT;
				end
			end
			ST_COUNT: begin
				if (status.count_done || status.too_long) state_d = ST_PRIME_INIT;
				else cmd.count_step = 1'b1;
			end
			ST_PRIME_INIT: begin
				cmd.prime_init = 1'b1;
				sel_d   = DIV_TWO;
				state_d = ST_DIV_START;
			end
			ST_DIV_START: begin
				if (status.small_decided) begin
					verdict_d = status.small_prime;
					state_d   = ST_PRIME_DONE;
				end else if ((sel_q == DIV_LOW) && status.sq_over) begin
					verdict_d = 1'b1;
					state_d   = ST_PRIME_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV_WAIT;
				end
			end
			ST_DIV_WAIT: begin
				if (status.div_done) begin
					if (status.rem_zero) begin
						verdict_d = 1'b0;
						state_d   = ST_PRIME_DONE;
					end else begin
						state_d = ST_DIV_START;
						case (sel_q)
							DIV_TWO:   sel_d = DIV_THREE;
							DIV_THREE: sel_d = DIV_LOW;
							DIV_LOW:   sel_d = DIV_HIGH;
							DIV_HIGH: begin
								sel_d = DIV_LOW;
								cmd.next_pair = 1'b1;
							end
							default:   sel_d = DIV_TWO;
						endcase
					end
				end
			end
			ST_PRIME_DONE: begin
				if (on_input_q) begin
					cmd.record_prime = 1'b1;
					on_input_d = 1'b0;
					if (status.too_long) begin
						cmd.fail_circ = 1'b1;
						state_d = ST_REPORT;
					end else state_d = ST_PRIME_INIT;
				end else if (!verdict_q) begin
					cmd.fail_circ = 1'b1;
					state_d = ST_REPORT;
				end else if (status.last_rotation) begin
					state_d = ST_REPORT;
				end else begin
					cmd.rot_start = 1'b1;
					state_d = ST_ROT_WAIT;
				end
			end
			ST_ROT_WAIT: begin
				state_d = ST_ROTATE;
			end
			ST_ROTATE: begin
				cmd.rot_load = 1'b1;
				state_d = ST_PRIME_INIT;
			end
			ST_REPORT: begin
				cmd.out_valid = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTH
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == ST_IDLE) else $error("load outside idle");
	a_report_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_valid |=> state_q == ST_IDLE) else $error("report not followed by idle");
	a_one_launch: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.div_start && cmd.rot_start)) else $error("two divider launches");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/circular_prime_test_unit.sv =====
`default_nettype none
// channel  | signals                    | handshake
// in       | value[29:0]                | start & !busy
// out      | is_circular, is_prime      | done strobe, one cycle
// Digit counting takes one step per digit. Each prime test checks 2 and 3
// without the divider, then takes the 6k-1 and 6k+1 remainders in turn on
// the restoring divider until d*d exceeds the value under test; a nine-digit
// prime needs about 5300 pairs.
// The input is tested, then each rotation, so up to ten tests.
// Reset clears the controller; busy stays high through the report state and the
// done strobe follows in the cycle after it. The receiver cannot stall.
module circular_prime_test_unit
	import cpt_pkg::*;
#(
	parameter int MAX_DIGITS = 9
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [29:0] value,
	output logic             busy,
	output logic             done,
	output logic             is_circular,
	output logic             is_prime
);
	cpt_cmd_t    cmd;
	cpt_status_t st;
	logic        done_q;

	cpt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.status(st), .cmd(cmd)
	);

	cpt_datapath #(.MAX_DIGITS(MAX_DIGITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .value(value), .cmd(cmd), .status(st),
		.is_circular(is_circular), .is_prime(is_prime)
	);

	// result strobe lines up with the registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= cmd.out_valid;
	end
	assign done = done_q;

endmodule
`default_nettype wire

// ===== tb/circular_prime_test_checker.sv =====
`timescale 1ns / 1ps
module circular_prime_test_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [29:0] value,
	input  wire logic        done,
	input  wire logic        is_circular,
	input  wire logic        is_prime,
	output int               fail_count,
	output int               pending
);
	localparam int MAX_DIGITS = 9;

	typedef struct packed {
		logic circ;
		logic prime;
	} verdict_t;

	verdict_t verdict_q[$];

	// trial division by 2, 3 and 6k+-1
	function automatic logic prime_check(input logic [29:0] n);
		longint unsigned d;
		if (n <= 1) return 1'b0;
		if (n <= 3) return 1'b1;
		if (n % 2 == 0 || n % 3 == 0) return 1'b0;
		for (d = 5; d * d <= n; d += 6)
			if (n % d == 0 || n % (d + 2) == 0) return 1'b0;
		return 1'b1;
	endfunction

	// expected flags for one input word
	function automatic verdict_t circular_verdict(input logic [29:0] v);
		verdict_t r;
		int unsigned len, pw, t, n;
		logic too_long;
		len = 1;
		pw = 1;
		t = v;
		too_long = 1'b0;
		while (t >= 10) begin
			t /= 10;
			if (len >= MAX_DIGITS) begin
				too_long = 1'b1;
				break;
			end
			len++;
			pw *= 10;
		end
		r.prime = prime_check(v);
		r.circ = !too_long;
		if (!too_long) begin
			n = v;
			for (int i = 0; i < len; i++) begin
				if (!prime_check(n[29:0])) begin
					r.circ = 1'b0;
					break;
				end
				n = (n % 10) * pw + n / 10;
			end
		end
		return r;
	endfunction

	// predict on accepted words, compare on strobes
	always @(posedge clk or negedge arst_n) begin
		verdict_t exp_v;
		if (!arst_n) begin
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (done) begin
				if (verdict_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result word circ=%0b prime=%0b",
							is_circular, is_prime);
					fail_count <= fail_count + 1;
				end else begin
					exp_v = verdict_q.pop_front();
					if (exp_v.circ !== is_circular || exp_v.prime !== is_prime) begin
						if (fail_count < 10)
							$display("mismatch: expected circ=%0b prime=%0b got circ=%0b prime=%0b",
								exp_v.circ, exp_v.prime, is_circular, is_prime);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy)
				verdict_q.push_back(circular_verdict(value));
			pending <= verdict_q.size();
		end
	end
endmodule

// ===== tb/circular_prime_test_unit_test.sv =====
`timescale 1ns / 1ps
module circular_prime_test_unit_test;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [29:0] value = '0;
	logic busy, done, is_circular, is_prime;
	int fail_count, pending;
	int idle_cycles = 0;

	localparam int WATCHDOG_LIMIT = 20000000;

	circular_prime_test_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .value(value),
		.busy(busy), .done(done), .is_circular(is_circular), .is_prime(is_prime)
	);

	circular_prime_test_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .value(value),
		.done(done), .is_circular(is_circular), .is_prime(is_prime),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog on cycles with no accepted word and no result
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// drive one word, hold start until accepted
	task automatic send_word(input logic [29:0] v);
		int gap;
		gap = $urandom_range(0, 10);
		repeat (gap) @(negedge clk);
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
		@(negedge clk);
		start <= 1'b0;
	endtask

	// mostly small values and some circular primes
	function automatic logic [29:0] random_word();
		int unsigned sel;
		logic [29:0] circ_set[12] = '{2, 7, 11, 13, 197, 199, 1193, 3779,
			11939, 19937, 193939, 199933};
		sel = $urandom_range(0, 99);
		if (sel < 25) return circ_set[$urandom_range(0, 11)];
		if (sel < 55) return 30'($urandom_range(0, 9999));
		if (sel < 75) return 30'($urandom_range(0, 999999));
		if (sel < 85) return 30'($urandom_range(0, 999999999));
		if (sel < 92) return 30'($urandom_range(1000000000, 30'h3FFFFFFF));
		return 30'($urandom);
	endfunction

	initial begin
		logic [29:0] directed[$] = '{0, 1, 2, 3, 4, 5, 9, 10, 11, 101, 103,
			113, 131, 197, 1009, 999999937, 999999999, 999999998,
			1000000000, 1000000007, 30'h3FFFFFFF, 30'h2AAAAAAA, 30'h15555555,
			199933, 1000003};
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (directed[i]) send_word(directed[i]);
		// let everything drain before random traffic
		wait (pending == 0);
		@(negedge clk);
		for (int i = 0; i < 125; i++) begin
			send_word(random_word());
			if (i == 60) begin
				wait (pending == 0);
				@(negedge clk);
			end
		end
		wait (pending == 0);
		repeat (50) @(negedge clk);
		if (fail_count == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end
endmodule

// ===== files.f =====
hw/rtl/cpt_pkg.sv
hw/rtl/cpt_divider.sv
hw/rtl/cpt_datapath.sv
hw/rtl/cpt_ctrl.sv
hw/rtl/circular_prime_test_unit.sv
tb/circular_prime_test_checker.sv
tb/circular_prime_test_unit_test.sv
